@@ rtl/core/stok_pkg.sv @@
`timescale 1ns / 1ps

package stok_pkg;

    localparam int TOKEN_BUFFER = 1024;
    localparam int CNT_W        = $clog2(TOKEN_BUFFER);
    localparam logic [CNT_W-1:0] TOK_LIMIT = CNT_W'(TOKEN_BUFFER - 1);

    localparam int LEN_W = 10;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam int MAX_RES   = 4;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);
    localparam int RES_IDX_W = $clog2(MAX_RES);

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        M_SKIP,
        M_SLASH,
        M_COMMENT,
        M_QUOTE,
        M_WORD
    } t_mode;

    typedef enum logic [1:0] {
        CL_WORD,
        CL_QUOTE,
        CL_BREAK
    } t_class;

    typedef struct packed {
        logic             is_end;
        logic [7:0]       token_byte;
        t_class           token_class;
        logic [LEN_W-1:0] token_length;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]  n;
        t_result [MAX_RES-1:0] res;
    } t_push;

    function automatic logic is_white(input logic [7:0] c);
        return (c <= CH_SPACE) || c[7];
    endfunction

    function automatic logic is_break(input logic [7:0] c, input logic ign_colons);
        if (c == CH_COLON) begin
            return !ign_colons;
        end
        return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
               (c == CH_RPAREN) || (c == CH_APOS) || (c == CH_COMMA);
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] k);
        if (32'(k) > 32'(LEN_MAX)) begin
            return LEN_MAX;
        end
        return LEN_W'(k);
    endfunction

    function automatic t_result make_byte(input logic [7:0] c, input t_class cls);
        t_result r;
        r.is_end       = 1'b0;
        r.token_byte   = c;
        r.token_class  = cls;
        r.token_length = '0;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic t_result make_end(input t_class cls, input logic [CNT_W-1:0] k);
        t_result r;
        r.is_end       = 1'b1;
        r.token_byte   = CH_NUL;
        r.token_class  = cls;
        r.token_length = sat_len(k);
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/core/stok_if.sv @@
`timescale 1ns / 1ps

interface stok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface stok_out_if;
    logic       valid;
    logic       ready;
    logic       is_end;
    logic [7:0] token_byte;
    logic [1:0] token_class;
    logic [9:0] token_length;
    logic       last;

    modport source (output valid, output is_end, output token_byte, output token_class,
                    output token_length, output last, input ready);
    modport sink (input valid, input is_end, input token_byte, input token_class,
                  input token_length, input last, output ready);
endinterface

interface stok_cfg_if;
    logic valid;
    logic ready;
    logic ignore_colons;

    modport source (output valid, output ignore_colons, input ready);
    modport sink (input valid, input ignore_colons, output ready);
endinterface

@@ rtl/core/stok_step.sv @@
`timescale 1ns / 1ps

module stok_step
    import stok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    stok_in_if.sink    i_text,
    stok_cfg_if.sink   i_cfg,
    input  logic       i_room,
    output t_push      o_push
);

    logic             r_valid;
    logic [7:0]       r_byte;
    t_mode            r_mode;
    logic [CNT_W-1:0] r_count;
    logic             r_ign;

    t_mode            n_mode;
    logic [CNT_W-1:0] n_count;

    logic                  advance;
    logic                  in_ready;
    logic [7:0]            c;
    logic [CNT_W-1:0]      k;
    logic [RES_CNT_W-1:0]  idx;
    t_result [MAX_RES-1:0] res;
    logic                  do_word;
    logic                  do_skip;

    assign advance        = r_valid && i_room;
    assign in_ready       = !r_valid || i_room;
    assign i_text.ready   = in_ready;
    assign i_cfg.ready    = 1'b1;

    always_comb begin
        c       = r_byte;
        k       = r_count;
        n_mode  = r_mode;
        n_count = r_count;
        idx     = '0;
        res     = '0;
        do_word = 1'b0;
        do_skip = 1'b0;

        case (r_mode)
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    n_mode = M_COMMENT;
                end else begin
                    res[0]  = make_byte(CH_SLASH, CL_WORD);
                    idx     = RES_CNT_W'(1);
                    k       = CNT_W'(1);
                    n_count = k;
                    if (k >= TOK_LIMIT) begin
                        res[1]  = make_end(CL_WORD, k);
                        idx     = RES_CNT_W'(2);
                        do_skip = 1'b1;
                    end else begin
                        do_word = 1'b1;
                    end
                end
            end
            M_COMMENT: begin
                if (c == CH_NL || c == CH_NUL) begin
                    n_mode = M_SKIP;
                end
            end
            M_QUOTE: begin
                if (c == CH_QUOTE || c == CH_NUL || r_count >= TOK_LIMIT) begin
                    res[0] = make_end(CL_QUOTE, r_count);
                    idx    = RES_CNT_W'(1);
                    n_mode = M_SKIP;
                end else begin
                    res[0]  = make_byte(c, CL_QUOTE);
                    idx     = RES_CNT_W'(1);
                    n_count = r_count + CNT_W'(1);
                end
            end
            M_WORD: begin
                do_word = 1'b1;
            end
            default: begin
                do_skip = 1'b1;
            end
        endcase

        if (do_word) begin
            if (is_white(c) || is_break(c, r_ign)) begin
                res[idx[RES_IDX_W-1:0]] = make_end(CL_WORD, k);
                idx     = idx + RES_CNT_W'(1);
                do_skip = 1'b1;
            end else begin
                res[idx[RES_IDX_W-1:0]] = make_byte(c, CL_WORD);
                idx     = idx + RES_CNT_W'(1);
                k       = k + CNT_W'(1);
                n_count = k;
                if (k >= TOK_LIMIT) begin
                    res[idx[RES_IDX_W-1:0]] = make_end(CL_WORD, k);
                    idx    = idx + RES_CNT_W'(1);
                    n_mode = M_SKIP;
                end else begin
                    n_mode = M_WORD;
                end
            end
        end

        if (do_skip) begin
            n_mode = M_SKIP;
            if (is_white(c)) begin
                n_mode = M_SKIP;
            end else if (c == CH_SLASH) begin
                n_mode = M_SLASH;
            end else if (c == CH_QUOTE) begin
                n_count = '0;
                n_mode  = M_QUOTE;
            end else if (is_break(c, r_ign)) begin
                res[idx[RES_IDX_W-1:0]] = make_byte(c, CL_BREAK);
                idx = idx + RES_CNT_W'(1);
                res[idx[RES_IDX_W-1:0]] = make_end(CL_BREAK, CNT_W'(1));
                idx = idx + RES_CNT_W'(1);
            end else begin
                res[idx[RES_IDX_W-1:0]] = make_byte(c, CL_WORD);
                idx     = idx + RES_CNT_W'(1);
                n_count = CNT_W'(1);
                if (CNT_W'(1) >= TOK_LIMIT) begin
                    res[idx[RES_IDX_W-1:0]] = make_end(CL_WORD, CNT_W'(1));
                    idx = idx + RES_CNT_W'(1);
                end else begin
                    n_mode = M_WORD;
                end
            end
        end

        if (idx != '0) begin
            res[RES_IDX_W'(idx - RES_CNT_W'(1))].last = 1'b1;
        end
    end

    assign o_push.n   = advance ? idx : '0;
    assign o_push.res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= M_SKIP;
            r_count <= '0;
            r_ign   <= 1'b0;
        end else begin
            if (in_ready) begin
                r_valid <= i_text.valid;
            end
            if (advance) begin
                r_mode  <= n_mode;
                r_count <= n_count;
            end
            if (i_cfg.valid) begin
                r_ign <= i_cfg.ignore_colons;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_text.valid) begin
            r_byte <= i_text.text_byte;
        end
    end

endmodule

@@ rtl/core/stok_res_fifo.sv @@
`timescale 1ns / 1ps

module stok_res_fifo
    import stok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    stok_out_if.source o_token
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;

    logic    pop;
    t_result head;

    assign o_room = r_count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RES);
    assign pop    = o_token.valid && o_token.ready;
    assign head   = r_mem[r_rd_ptr];

    assign o_token.valid        = r_count != '0;
    assign o_token.is_end       = head.is_end;
    assign o_token.token_byte   = head.token_byte;
    assign o_token.token_class  = head.token_class;
    assign o_token.token_length = head.token_length;
    assign o_token.last         = head.last;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (RES_CNT_W'(i) < i_push.n) begin
                r_mem[FIFO_PTR_W'(r_wr_ptr + FIFO_PTR_W'(i))] <= i_push.res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push.n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push.n) - FIFO_CNT_W'(pop);
        end
    end

endmodule

@@ rtl/core/script_tokenizer_top.sv @@
`timescale 1ns / 1ps

// Streaming tokeniser: text bytes arrive on i_text, one byte per transaction, and
// tokens leave on o_token as a run of byte results closed by an end marker that
// gives the token's class and length. Each result flagged last is the final one
// caused by its input byte; a byte may cause no result at all.
// i_cfg writes the ignore_colons register; it is always ready and should be
// written only while the block is idle.
// Each byte is registered in the scanner, whose results for it are written into
// the result queue; o_token is driven from the head of that queue.
// Throughput: one byte per cycle while the result queue has room for the up to
// four results a byte may cause; the queue drains one result per cycle while the
// receiver is ready, so a byte causing several results holds the input back.
// When the receiver stalls, the eight-entry result queue fills until it lacks room
// for four more results and i_text.ready falls; the result on o_token is held until it is taken.
// Synchronous reset empties the queue, returns the scanner to skipping
// whitespace with a zero token length and clears ignore_colons.

module script_tokenizer_top
    import stok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    stok_in_if.sink    i_text,
    stok_cfg_if.sink   i_cfg,
    stok_out_if.source o_token
);

    t_push push;
    logic  room;

    stok_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (i_text),
        .i_cfg   (i_cfg),
        .i_room  (room),
        .o_push  (push)
    );

    stok_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_token (o_token)
    );

endmodule

@@ rtl/core/stok_checker.sv @@
`timescale 1ns / 1ps

module stok_checker
    import stok_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_is_end,
    input logic [7:0] i_token_byte,
    input logic [1:0] i_token_class,
    input logic [9:0] i_token_length
);

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_valid)
        else $error("result offered straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_is_end) && $stable(i_token_byte)
            && $stable(i_token_class) && $stable(i_token_length))
        else $error("stalled result changed");

    a_end_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_end |-> i_token_byte == CH_NUL)
        else $error("end marker carries a byte");

    a_byte_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_is_end |-> i_token_length == '0)
        else $error("token byte carries a length");

    a_break_len_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_end && i_token_class == CL_BREAK |-> i_token_length == 10'd1)
        else $error("break token length is not one");

endmodule

bind script_tokenizer_top stok_checker u_stok_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_token.valid),
    .i_ready        (o_token.ready),
    .i_is_end       (o_token.is_end),
    .i_token_byte   (o_token.token_byte),
    .i_token_class  (o_token.token_class),
    .i_token_length (o_token.token_length)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import stok_pkg::*;

    localparam int SETTLE_CYCLES = 8;

    typedef enum {
        ROW_TEXT,
        ROW_CONFIG
    } t_row_kind;

    typedef struct {
        t_row_kind       kind;
        logic [7:0]      chr;
        int unsigned     reps;
        bit              known;
        int unsigned     n_known;
        t_result [1:0]   known_res;
        logic            colon_off;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;

    stok_in_if  text_if ();
    stok_cfg_if cfg_if ();
    stok_out_if token_if ();

    script_tokenizer_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_text  (text_if),
        .i_cfg   (cfg_if),
        .o_token (token_if)
    );

    t_mode       scan_mode_m;
    int unsigned tok_len_m;
    logic        ign_colons_m;
    t_result     byte_results[$];
    t_result     expected_tokens[$];
    t_result     next_token;
    t_stim_row   stim_table[$];
    logic [7:0]  text_chunk[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatch_count = 0;

    always #6 clk = ~clk;

    // Tokeniser predictor.
    function automatic bit blank_char(logic [7:0] c);
        return (c <= CH_SPACE) || (c >= 8'd128);
    endfunction

    function automatic bit break_char(logic [7:0] c);
        if (c == CH_COLON) begin
            return !ign_colons_m;
        end
        return c inside {CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_APOS, CH_COMMA};
    endfunction

    function automatic void emit_res(logic fin, logic [7:0] c, t_class cls, int unsigned len);
        t_result r;
        r.is_end       = fin;
        r.token_byte   = fin ? CH_NUL : c;
        r.token_class  = cls;
        r.token_length = fin ? ((len > 32'(LEN_MAX)) ? LEN_MAX : LEN_W'(len)) : '0;
        r.last         = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void add_word_char(logic [7:0] c);
        emit_res(1'b0, c, CL_WORD, 0);
        tok_len_m++;
        if (tok_len_m >= 32'(TOK_LIMIT)) begin
            emit_res(1'b1, CH_NUL, CL_WORD, tok_len_m);
            scan_mode_m = M_SKIP;
        end else begin
            scan_mode_m = M_WORD;
        end
    endfunction

    function automatic void start_token(logic [7:0] c);
        scan_mode_m = M_SKIP;
        if (blank_char(c)) begin
            return;
        end
        if (c == CH_SLASH) begin
            scan_mode_m = M_SLASH;
        end else if (c == CH_QUOTE) begin
            tok_len_m   = 0;
            scan_mode_m = M_QUOTE;
        end else if (break_char(c)) begin
            emit_res(1'b0, c, CL_BREAK, 0);
            emit_res(1'b1, CH_NUL, CL_BREAK, 1);
        end else begin
            tok_len_m = 0;
            add_word_char(c);
        end
    endfunction

    function automatic void continue_word(logic [7:0] c);
        if (blank_char(c) || break_char(c)) begin
            emit_res(1'b1, CH_NUL, CL_WORD, tok_len_m);
            start_token(c);
        end else begin
            add_word_char(c);
        end
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        t_result r;
        byte_results.delete();
        case (scan_mode_m)
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    scan_mode_m = M_COMMENT;
                end else begin
                    tok_len_m = 0;
                    add_word_char(CH_SLASH);
                    if (scan_mode_m == M_WORD) begin
                        continue_word(c);
                    end else begin
                        start_token(c);
                    end
                end
            end
            M_COMMENT: begin
                if (c == CH_NL || c == CH_NUL) begin
                    scan_mode_m = M_SKIP;
                end
            end
            M_QUOTE: begin
                if (c == CH_QUOTE || c == CH_NUL || tok_len_m >= 32'(TOK_LIMIT)) begin
                    emit_res(1'b1, CH_NUL, CL_QUOTE, tok_len_m);
                    scan_mode_m = M_SKIP;
                end else begin
                    emit_res(1'b0, c, CL_QUOTE, 0);
                    tok_len_m++;
                end
            end
            M_WORD: begin
                continue_word(c);
            end
            default: begin
                start_token(c);
            end
        endcase
        if (byte_results.size() > 0) begin
            r      = byte_results.pop_back();
            r.last = 1'b1;
            byte_results.push_back(r);
        end
    endfunction

    function automatic t_result chr_res(logic [7:0] c, t_class cls, logic last);
        t_result r;
        r              = '0;
        r.token_byte   = c;
        r.token_class  = cls;
        r.last         = last;
        return r;
    endfunction

    function automatic t_result end_res(t_class cls, int unsigned len, logic last);
        t_result r;
        r              = '0;
        r.is_end       = 1'b1;
        r.token_class  = cls;
        r.token_length = LEN_W'(len);
        r.last         = last;
        return r;
    endfunction

    function automatic void row_text(logic [7:0] c, int unsigned reps);
        t_stim_row row;
        row           = '{kind: ROW_TEXT, default: '0};
        row.kind      = ROW_TEXT;
        row.chr       = c;
        row.reps      = reps;
        stim_table.push_back(row);
    endfunction

    function automatic void row_known(logic [7:0] c, int unsigned n, t_result r0, t_result r1);
        t_stim_row row;
        row           = '{kind: ROW_TEXT, default: '0};
        row.kind      = ROW_TEXT;
        row.chr       = c;
        row.reps      = 1;
        row.known     = 1'b1;
        row.n_known   = n;
        row.known_res = {r1, r0};
        stim_table.push_back(row);
    endfunction

    function automatic void row_config(logic v);
        t_stim_row row;
        row           = '{kind: ROW_CONFIG, default: '0};
        row.kind      = ROW_CONFIG;
        row.colon_off = v;
        stim_table.push_back(row);
    endfunction

    function automatic void build_table();
        row_config(1'b0);
        row_known(CH_LBRACE, 2, chr_res(CH_LBRACE, CL_BREAK, 1'b0), end_res(CL_BREAK, 1, 1'b1));
        row_known(CH_COLON, 2, chr_res(CH_COLON, CL_BREAK, 1'b0), end_res(CL_BREAK, 1, 1'b1));
        row_known(CH_SPACE, 0, '0, '0);
        row_known(8'h01, 0, '0, '0);
        row_known(8'h80, 0, '0, '0);
        row_known(8'hFF, 0, '0, '0);
        row_text("a", 1);
        row_text(8'h7F, 1);
        row_text(CH_QUOTE, 1);
        row_text(CH_RPAREN, 1);
        row_text(CH_SLASH, 1);
        row_text("x", 1);
        row_text(CH_SPACE, 1);
        row_text(CH_SLASH, 2);
        row_text("q", 1);
        row_known(CH_NL, 0, '0, '0);
        row_known(CH_QUOTE, 0, '0, '0);
        row_text("h", 1);
        row_known(CH_QUOTE, 1, end_res(CL_QUOTE, 1, 1'b1), '0);
        row_known(CH_QUOTE, 0, '0, '0);
        row_known(CH_QUOTE, 1, end_res(CL_QUOTE, 0, 1'b1), '0);
        row_text("w", 1);
        row_text(CH_NUL, 1);
        row_text(CH_SLASH, 1);
        row_text(CH_NUL, 1);
        row_text(CH_SLASH, 2);
        row_text("z", 1);
        row_known(CH_NUL, 0, '0, '0);
        row_text(CH_QUOTE, 1);
        row_text("a", 1);
        row_text(CH_NUL, 1);
        row_text("k", 1030);
        row_text(CH_SPACE, 1);
        row_text(CH_QUOTE, 1);
        row_text("q", 1025);
        row_text(CH_QUOTE, 1);
        row_text(CH_SPACE, 1);
        row_text(CH_SLASH, 1);
        row_text(CH_LPAREN, 1);
        row_text(CH_SLASH, 1);
        row_text(CH_QUOTE, 1);
        row_text(CH_SPACE, 1);
        row_config(1'b1);
        row_text(CH_COLON, 1);
        row_text("b", 1);
        row_text(CH_COLON, 1);
        row_text(CH_APOS, 1);
        row_text(CH_COMMA, 1);
        row_text(CH_RBRACE, 1);
        row_text(CH_LPAREN, 1);
        row_text(CH_NUL, 1);
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(33, 127));
        end while (break_char(c) || c == CH_SLASH || c == CH_QUOTE || c == CH_COLON);
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        if ($urandom_range(0, 1) == 0) begin
            return 8'($urandom_range(1, 32));
        end
        return 8'($urandom_range(128, 255));
    endfunction

    // Builds one random fragment of text; whitespace runs are not counted as items.
    function automatic void make_chunk(output bit counted);
        int unsigned kind;
        int unsigned n;
        logic [7:0]  c;
        logic [7:0]  breaks[7];
        breaks  = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_APOS, CH_COMMA, CH_COLON};
        text_chunk.delete();
        counted = 1'b1;
        kind    = $urandom_range(0, 99);
        if (kind < 30) begin
            n = $urandom_range(1, 12);
            text_chunk.push_back(word_char());
            for (int k = 1; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    text_chunk.push_back(($urandom_range(0, 1) == 0) ? CH_QUOTE : CH_SLASH);
                end else begin
                    text_chunk.push_back(word_char());
                end
            end
        end else if (kind < 45) begin
            counted = 1'b0;
            n = $urandom_range(1, 3);
            repeat (n) text_chunk.push_back(blank_byte());
        end else if (kind < 60) begin
            text_chunk.push_back(CH_QUOTE);
            n = $urandom_range(0, 10);
            repeat (n) begin
                do begin
                    c = 8'($urandom_range(1, 255));
                end while (c == CH_QUOTE);
                text_chunk.push_back(c);
            end
            text_chunk.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : CH_QUOTE);
        end else if (kind < 68) begin
            text_chunk.push_back(CH_SLASH);
            text_chunk.push_back(CH_SLASH);
            n = $urandom_range(0, 8);
            repeat (n) begin
                do begin
                    c = 8'($urandom_range(1, 255));
                end while (c == CH_NL);
                text_chunk.push_back(c);
            end
            text_chunk.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : CH_NL);
        end else if (kind < 80) begin
            text_chunk.push_back(breaks[$urandom_range(0, 6)]);
        end else if (kind < 87) begin
            text_chunk.push_back(CH_SLASH);
            text_chunk.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 92) begin
            text_chunk.push_back(CH_NUL);
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) text_chunk.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(logic [7:0] c, bit known, int unsigned n_known,
                             t_result [1:0] known_res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            text_if.valid <= 1'b0;
            @(negedge clk);
        end
        text_if.valid     <= 1'b1;
        text_if.text_byte <= c;
        @(posedge clk);
        while (!text_if.ready) @(posedge clk);
        predict_byte(c);
        if (known) begin
            for (int k = 0; k < n_known; k++) expected_tokens.push_back(known_res[k]);
        end else begin
            foreach (byte_results[k]) expected_tokens.push_back(byte_results[k]);
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        text_if.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(logic v);
        cfg_if.valid         <= 1'b1;
        cfg_if.ignore_colons <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        ign_colons_m = v;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_random(int unsigned n_items);
        int unsigned sent;
        bit          paused;
        bit          counted;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!paused && sent >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            make_chunk(counted);
            foreach (text_chunk[k]) send_byte(text_chunk[k], 1'b0, 0, '0);
            if (counted) begin
                sent += text_chunk.size();
            end
        end
    endtask

    always @(negedge clk) begin
        token_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Each token transaction is compared with the oldest outstanding expectation.
    always @(posedge clk) begin
        if (rst_n && token_if.valid && token_if.ready) begin
            if (expected_tokens.size() == 0) begin
                $error("token transaction with no result outstanding");
                mismatch_count++;
            end else begin
                next_token = expected_tokens.pop_front();
                if (token_if.is_end !== next_token.is_end) begin
                    $error("is_end: expected %0d, got %0d", next_token.is_end, token_if.is_end);
                    mismatch_count++;
                end
                if (token_if.token_byte !== next_token.token_byte) begin
                    $error("token_byte: expected %0h, got %0h",
                           next_token.token_byte, token_if.token_byte);
                    mismatch_count++;
                end
                if (token_if.token_class !== 2'(next_token.token_class)) begin
                    $error("token_class: expected %0d, got %0d",
                           next_token.token_class, token_if.token_class);
                    mismatch_count++;
                end
                if (token_if.token_length !== next_token.token_length) begin
                    $error("token_length: expected %0d, got %0d",
                           next_token.token_length, token_if.token_length);
                    mismatch_count++;
                end
                if (token_if.last !== next_token.last) begin
                    $error("last: expected %0d, got %0d", next_token.last, token_if.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        rst_n                = 1'b0;
        text_if.valid        = 1'b0;
        text_if.text_byte    = 8'h00;
        cfg_if.valid         = 1'b0;
        cfg_if.ignore_colons = 1'b0;
        scan_mode_m          = M_SKIP;
        tok_len_m            = 0;
        ign_colons_m         = 1'b0;
        send_idle_pct        = 36;
        recv_idle_pct        = 71;
        build_table();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CONFIG) begin
                wait_drained();
                write_cfg(stim_table[i].colon_off);
            end else begin
                repeat (stim_table[i].reps) begin
                    send_byte(stim_table[i].chr, stim_table[i].known,
                              stim_table[i].n_known, stim_table[i].known_res);
                end
            end
        end

        wait_drained();
        write_cfg(1'b1);
        run_random(124);

        wait_drained();
        send_idle_pct = 71;
        recv_idle_pct = 36;
        write_cfg(1'b0);
        run_random(123);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(1'($urandom_range(0, 1)));
        run_random(123);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ script_tokenizer_top.f @@
rtl/core/stok_pkg.sv
rtl/core/stok_if.sv
rtl/core/stok_step.sv
rtl/core/stok_res_fifo.sv
rtl/core/script_tokenizer_top.sv
rtl/core/stok_checker.sv
test/tb_top.sv
